[rtl/bscf_pkg.sv]
// Package for the byte stream character framer.
// Holds opcodes, byte constants and the table reset and lead-length functions.
// No dependencies.
package bscf_pkg;

    localparam int unsigned CODE_W = 32;
    localparam int unsigned LEN_W  = 3;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TBL_DEPTH = 256;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [1:0] OP_DATA   = 2'd0;
    localparam logic [1:0] OP_FLUSH  = 2'd1;
    localparam logic [1:0] OP_TBL_WR = 2'd2;

    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    localparam logic [7:0] MASK_1 = 8'h80;
    localparam logic [7:0] MASK_2 = 8'hE0;
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] MASK_3 = 8'hF0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] MASK_4 = 8'hF8;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] TRAIL_MASK = 8'hC0;
    localparam logic [7:0] TRAIL_VAL  = 8'h80;

    localparam logic [CODE_W-1:0] DOT_CODE = {24'd0, CHAR_DOT};

    function automatic logic [CODE_W-1:0] tbl_reset_val(input logic [7:0] idx);
        logic [CODE_W-1:0] val;
        if (idx >= PRINT_LO && idx <= PRINT_HI)
            val = {24'd0, idx};
        else
            val = DOT_CODE;
        return val;
    endfunction

    function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        if ((b & MASK_1) == 8'h00)
            len = 3'd1;
        else if ((b & MASK_2) == LEAD_2)
            len = 3'd2;
        else if ((b & MASK_3) == LEAD_3)
            len = 3'd3;
        else if ((b & MASK_4) == LEAD_4)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

endpackage

[rtl/byte_stream_char_framer.sv]
// Byte stream character framer: UTF-8 framing or 256-word table translation.
// Depends on bscf_pkg. Table lives in a synchronous RAM with a registered read.
// Each result is staged in the job registers, then in the output register, before it leaves.
// Throughput: one input word per cycle; a word giving several results holds the input until the
// single result sequencer has sent them all to the output register; backpressure adds stalls.
// Reset: async active low; clears framing state, mode, output valid and table valid bits,
// so every table entry reads its default until written.
module byte_stream_char_framer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,      // decode_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,     // data_byte, table_index, table_value
    input  logic [1:0]  s_axis_tuser,     // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,     // char_code, char_length, zero pad
    output logic        m_axis_tuser,     // invalid_byte
    output logic        m_axis_tlast      // last_of_run
);
    import bscf_pkg::*;

    logic [7:0]        in_byte;
    logic [7:0]        in_idx;
    logic [CODE_W-1:0] in_val;
    logic              accept;

    logic              mode_reg;
    logic [1:0]        pc_reg, pc_next;
    logic [LEN_W-1:0]  el_reg, el_next;
    logic              cr_reg, cr_next;
    logic [7:0]        pend_reg [3];
    logic              pend_we;
    logic [1:0]        pend_idx;

    logic [CODE_W-1:0]    table_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] tbl_valid_reg;
    logic [CODE_W-1:0]    rd_data_reg;
    logic                 rd_valid_reg;
    logic [7:0]           rd_addr_reg;
    logic                 tbl_rd;
    logic                 tbl_wr;

    logic              lead_fr;
    logic [LEN_W-1:0]  ll;
    logic [1:0]        new_dots;
    logic              new_fin;
    logic              new_tbl;
    logic [CODE_W-1:0] new_code;
    logic [LEN_W-1:0]  new_len;
    logic              new_inv;

    logic              job_valid_reg;
    logic [1:0]        job_dots_reg;
    logic              job_fin_reg;
    logic              job_tbl_reg;
    logic [CODE_W-1:0] job_code_reg;
    logic [LEN_W-1:0]  job_len_reg;
    logic              job_inv_reg;
    logic              job_step;
    logic              job_last;
    logic              job_done;

    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_inv_reg;
    logic              out_last_reg;
    logic              out_adv;
    logic [CODE_W-1:0] fin_code;

    assign in_byte = s_axis_tdata[7:0];
    assign in_idx  = s_axis_tdata[15:8];
    assign in_val  = s_axis_tdata[47:16];

    assign out_adv  = !out_valid_reg || m_axis_tready;
    assign job_step = job_valid_reg && out_adv;
    assign job_last = (job_dots_reg == 2'd0) || (job_dots_reg == 2'd1 && !job_fin_reg);
    assign job_done = job_step && job_last;
    assign s_axis_tready = !job_valid_reg || job_done;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign tbl_wr = accept && s_axis_tuser == OP_TBL_WR;
    assign tbl_rd = accept && s_axis_tuser == OP_DATA && !mode_reg;
    assign ll = lead_len(in_byte);

    always_comb
    begin
        new_dots = 2'd0;
        new_fin  = 1'b0;
        new_tbl  = 1'b0;
        new_code = {24'd0, in_byte};
        new_len  = 3'd1;
        new_inv  = 1'b0;
        pc_next  = pc_reg;
        el_next  = el_reg;
        cr_next  = cr_reg;
        pend_we  = 1'b0;
        pend_idx = pc_reg;
        lead_fr  = 1'b0;
        case (s_axis_tuser)
            OP_DATA:
            begin
                if (mode_reg)
                begin
                    cr_next = 1'b0;
                    if (pc_reg == 2'd0)
                        lead_fr = 1'b1;
                    else if ((in_byte & TRAIL_MASK) != TRAIL_VAL)
                    begin
                        new_dots = pc_reg;
                        pc_next  = 2'd0;
                        el_next  = 3'd0;
                        lead_fr  = 1'b1;
                    end
                    else if ({1'b0, pc_reg} + 3'd1 >= el_reg)
                    begin
                        new_fin = 1'b1;
                        new_len = {1'b0, pc_reg} + 3'd1;
                        case (pc_reg)
                            2'd1:    new_code = {16'd0, in_byte, pend_reg[0]};
                            2'd2:    new_code = {8'd0, in_byte, pend_reg[1], pend_reg[0]};
                            default: new_code = {in_byte, pend_reg[2], pend_reg[1],
                                                 pend_reg[0]};
                        endcase
                        pc_next = 2'd0;
                        el_next = 3'd0;
                    end
                    else
                    begin
                        pend_we = 1'b1;
                        pc_next = pc_reg + 2'd1;
                    end
                end
                else
                begin
                    if (in_byte == CHAR_LF && cr_reg)
                        cr_next = 1'b0;
                    else
                    begin
                        cr_next = (in_byte == CHAR_CR);
                        new_fin = 1'b1;
                        new_tbl = !(in_byte == CHAR_CR || in_byte == CHAR_LF ||
                                    in_byte == CHAR_TAB);
                    end
                end
            end
            OP_FLUSH:
            begin
                new_dots = pc_reg;
                pc_next  = 2'd0;
                el_next  = 3'd0;
                cr_next  = 1'b0;
            end
            default: ;
        endcase
        if (lead_fr)
        begin
            case (ll)
                3'd0:
                begin
                    new_fin  = 1'b1;
                    new_code = DOT_CODE;
                    new_len  = 3'd0;
                    new_inv  = 1'b1;
                end
                3'd1:
                    new_fin = 1'b1;
                default:
                begin
                    pend_we  = 1'b1;
                    pend_idx = 2'd0;
                    pc_next  = 2'd1;
                    el_next  = ll;
                end
            endcase
        end
    end

    // Table RAM: write on table write, registered read on table-mode byte.
    always_ff @(posedge clk)
    begin
        if (tbl_wr)
            table_mem[in_idx] <= in_val;
        if (tbl_rd)
        begin
            rd_data_reg <= table_mem[in_byte];
            rd_addr_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (tbl_wr)
                tbl_valid_reg[in_idx] <= 1'b1;
            if (tbl_rd)
                rd_valid_reg <= tbl_valid_reg[in_byte];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            pc_reg   <= 2'd0;
            el_reg   <= 3'd0;
            cr_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            if (accept)
            begin
                pc_reg <= pc_next;
                el_reg <= el_next;
                cr_reg <= cr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pend_we)
            pend_reg[pend_idx] <= in_byte;
    end

    // Result sequencer: dots first, then the final character.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_dots_reg  <= 2'd0;
            job_fin_reg   <= 1'b0;
        end
        else if (accept)
        begin
            job_valid_reg <= (new_dots != 2'd0) || new_fin;
            job_dots_reg  <= new_dots;
            job_fin_reg   <= new_fin;
        end
        else if (job_step)
        begin
            if (job_last)
                job_valid_reg <= 1'b0;
            else
                job_dots_reg <= job_dots_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_tbl_reg  <= new_tbl;
            job_code_reg <= new_code;
            job_len_reg  <= new_len;
            job_inv_reg  <= new_inv;
        end
    end

    assign fin_code = !job_tbl_reg ? job_code_reg :
                      rd_valid_reg ? rd_data_reg : tbl_reset_val(rd_addr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= job_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (job_step)
        begin
            out_last_reg <= job_last;
            if (job_dots_reg != 2'd0)
            begin
                out_code_reg <= DOT_CODE;
                out_len_reg  <= 3'd0;
                out_inv_reg  <= 1'b1;
            end
            else
            begin
                out_code_reg <= fin_code;
                out_len_reg  <= job_len_reg;
                out_inv_reg  <= job_inv_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_len_reg, out_code_reg};
    assign m_axis_tuser  = out_inv_reg;
    assign m_axis_tlast  = out_last_reg;

    a_len_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == 2'd0) == (el_reg == 3'd0))
        else $error("pending count and expected length disagree");

    a_pc_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != 2'd0) |-> ({1'b0, pc_reg} < el_reg))
        else $error("pending count reached expected length");

    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> (job_dots_reg != 2'd0 || job_fin_reg))
        else $error("job slot holds no result");

    a_out_follows_job: assert property (@(posedge clk) disable iff (!rst_n)
        (out_adv && !job_valid_reg) |=> !m_axis_tvalid)
        else $error("output valid without a job");

endmodule
